FILE: hdl/dorf_pkg.sv
// ----------------------------------------------------------------------------
// dorf_pkg
// Shared types, codes and helpers for the drop-oldest ring FIFO.
// ----------------------------------------------------------------------------
package dorf_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 64;

    localparam int OP_W     = 2;
    localparam int WORD_W   = 64;
    localparam int STATUS_W = 3;
    localparam int CAP_W    = 5;
    localparam int DROP_W   = 32;
    localparam int CAP_RST  = 16;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
    localparam logic [OP_W-1:0] OP_POP  = 2'd1;
    localparam logic [OP_W-1:0] OP_SHUT = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_PUSHED      = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_PUSHED_DROP = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_POPPED      = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_EMPTY       = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_EMPTY_SHUT  = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [WORD_W-1:0] push_data;
    } t_in;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [WORD_W-1:0]   pop_data;
        logic [CAP_W-1:0]    depth;
        logic [DROP_W-1:0]   drop_total;
    } t_out;

    typedef enum logic {
        S_IDLE,
        S_POP_RD
    } t_state;

    // advance a ring index, wrapping at the capacity in use
    function automatic logic [CAP_W-1:0] bump(input logic [CAP_W-1:0] idx,
                                              input logic [CAP_W-1:0] cap);
        logic [CAP_W:0] nxt;
        nxt = {1'b0, idx} + {{CAP_W{1'b0}}, 1'b1};
        return (nxt >= {1'b0, cap}) ? '0 : nxt[CAP_W-1:0];
    endfunction

endpackage

FILE: hdl/dorf_slot_ram.sv
// ----------------------------------------------------------------------------
// dorf_slot_ram
// Slot storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dorf_slot_ram #(
    parameter int DEPTH      = dorf_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dorf_pkg::DATA_WIDTH_DEF,
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_wr_en,
    input  logic [AW-1:0]         i_wr_addr,
    input  logic [DATA_WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]         i_rd_addr,
    output logic [DATA_WIDTH-1:0] o_rd_data
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/drop_oldest_ring_fifo.sv
// ----------------------------------------------------------------------------
// drop_oldest_ring_fifo
// Ring-buffer FIFO that drops its oldest entry when a push finds it full.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on i_in (op, push_data) when start is high and busy is
//   low. op: push, pop or shutdown request. Every command yields exactly one
//   transaction on o_result, marked by o_strobe for one cycle; the receiver
//   has no way to stall it.
//   Push, shutdown and unused ops: the result is registered and appears in
//   the cycle after acceptance; busy stays low, so one command per cycle.
//   Pop of a non-empty queue: the slot is read from the synchronous RAM at
//   the accept edge, so busy is high for one cycle and no new command is
//   taken meanwhile; the result passes the RAM read register and then the
//   output register. Empty pops answer in the cycle after acceptance.
//   APB register 0 (capacity_in_use, byte address 0) sets the slots in use
//   from pwdata[4:0]; 0 is taken as 1, values above DEPTH as DEPTH. Any
//   write empties the queue but keeps the shutdown flag and the drop total.
//   Reset empties the queue, clears shutdown and the drop total, and sets
//   the capacity to 16 (or DEPTH if smaller). No clearing pass is needed.
// ----------------------------------------------------------------------------
module drop_oldest_ring_fifo #(
    parameter int DEPTH      = dorf_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dorf_pkg::DATA_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  dorf_pkg::t_in      i_in,
    output logic               o_strobe,
    output dorf_pkg::t_out     o_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = dorf_pkg::CAP_W;
    localparam logic [CW-1:0] CAP_RST =
        (dorf_pkg::CAP_RST > DEPTH) ? CW'(DEPTH) : CW'(dorf_pkg::CAP_RST);

    dorf_pkg::t_state r_state, n_state;

    logic [CW-1:0]               r_capacity;
    logic [CW-1:0]               r_read_index, n_read_index;
    logic [CW-1:0]               r_write_index, n_write_index;
    logic [CW-1:0]               r_count, n_count;
    logic                        r_shut, n_shut;
    logic [dorf_pkg::DROP_W-1:0] r_drops, n_drops;
    dorf_pkg::t_out              r_out, n_out;
    logic                        r_out_vld, n_out_vld;

    logic                  accept;
    logic                  cfg_wr;
    logic [CW-1:0]         cfg_val;
    logic [CW-1:0]         cfg_cap;
    logic                  wr_en;
    logic                  pop_rd;
    logic                  full;
    logic [DATA_WIDTH-1:0] rd_data;

    assign accept = start && !busy;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {{(32-CW){1'b0}}, r_capacity} : '0;

    // clamp the written capacity into 1..DEPTH
    assign cfg_val = pwdata[CW-1:0];
    always_comb begin
        cfg_cap = cfg_val;
        if (cfg_val == '0) begin
            cfg_cap = {{(CW-1){1'b0}}, 1'b1};
        end else if ({{(32-CW){1'b0}}, cfg_val} > 32'(DEPTH)) begin
            cfg_cap = CW'(DEPTH);
        end
    end

    assign full = (r_count >= r_capacity);

    dorf_slot_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (AW'(r_write_index)),
        .i_wr_data (i_in.push_data[DATA_WIDTH-1:0]),
        .i_rd_addr (AW'(r_read_index)),
        .o_rd_data (rd_data)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dorf_pkg::S_IDLE: begin
                if (pop_rd) begin
                    n_state = dorf_pkg::S_POP_RD;
                end
            end
            dorf_pkg::S_POP_RD: begin
                n_state = dorf_pkg::S_IDLE;
            end
            default: begin
                n_state = dorf_pkg::S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        busy = 1'b0;
        case (r_state)
            dorf_pkg::S_IDLE:   busy = 1'b0;
            dorf_pkg::S_POP_RD: busy = 1'b1;
            default:            busy = 1'b0;
        endcase
    end

    // command datapath
    always_comb begin
        n_read_index  = r_read_index;
        n_write_index = r_write_index;
        n_count       = r_count;
        n_shut        = r_shut;
        n_drops       = r_drops;
        n_out         = r_out;
        n_out_vld     = 1'b0;
        wr_en         = 1'b0;
        pop_rd        = 1'b0;

        if (r_state == dorf_pkg::S_POP_RD) begin
            // read data is back from the RAM; status fields were set at accept
            n_out.pop_data = dorf_pkg::WORD_W'(rd_data);
            n_out_vld      = 1'b1;
        end else if (accept) begin
            n_out.status   = dorf_pkg::STAT_EMPTY;
            n_out.pop_data = '0;
            n_out_vld      = 1'b1;
            case (i_in.op)
                dorf_pkg::OP_PUSH: begin
                    wr_en         = 1'b1;
                    n_write_index = dorf_pkg::bump(r_write_index, r_capacity);
                    if (full) begin
                        n_read_index = dorf_pkg::bump(r_read_index, r_capacity);
                        n_drops      = r_drops + 1'b1;
                        n_out.status = dorf_pkg::STAT_PUSHED_DROP;
                    end else begin
                        n_count      = r_count + 1'b1;
                        n_out.status = dorf_pkg::STAT_PUSHED;
                    end
                end
                dorf_pkg::OP_POP: begin
                    if (r_count != '0) begin
                        pop_rd       = 1'b1;
                        n_read_index = dorf_pkg::bump(r_read_index, r_capacity);
                        n_count      = r_count - 1'b1;
                        n_out.status = dorf_pkg::STAT_POPPED;
                        n_out_vld    = 1'b0;
                    end else begin
                        n_out.status = r_shut ? dorf_pkg::STAT_EMPTY_SHUT
                                              : dorf_pkg::STAT_EMPTY;
                    end
                end
                dorf_pkg::OP_SHUT: begin
                    n_shut       = 1'b1;
                    n_out.status = dorf_pkg::STAT_EMPTY_SHUT;
                end
                default: begin
                    n_out.status = dorf_pkg::STAT_EMPTY;
                end
            endcase
            n_out.depth      = n_count;
            n_out.drop_total = n_drops;
        end

        if (cfg_wr) begin
            n_read_index  = '0;
            n_write_index = '0;
            n_count       = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= dorf_pkg::S_IDLE;
            r_capacity    <= CAP_RST;
            r_read_index  <= '0;
            r_write_index <= '0;
            r_count       <= '0;
            r_shut        <= 1'b0;
            r_drops       <= '0;
            r_out_vld     <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_read_index  <= n_read_index;
            r_write_index <= n_write_index;
            r_count       <= n_count;
            r_shut        <= n_shut;
            r_drops       <= n_drops;
            r_out_vld     <= n_out_vld;
            if (cfg_wr) begin
                r_capacity <= cfg_cap;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_strobe = r_out_vld;
    assign o_result = r_out;

endmodule
